/* rtl/core/htdsc_pkg.sv */
package htdsc_pkg;

  localparam int MAX_PATTERN_BYTES = 4;
  localparam int PAT_W = 32;
  localparam int PAT_BYTES = PAT_W / 8;
  localparam int LEN_W = 3;
  localparam int EFF_W = 4;
  localparam int MCNT_W = 3;

  localparam int STORE_DEPTH = 24;
  localparam int RCNT_W = 5;
  localparam logic [RCNT_W-1:0] REC_LAST_M0 = 5'd24;
  localparam logic [RCNT_W-1:0] REC_LAST_M1 = 5'd20;
  localparam logic [RCNT_W-1:0] PAY_LEN_M0 = 5'd24;
  localparam logic [RCNT_W-1:0] PAY_LEN_M1 = 5'd20;
  localparam logic [RCNT_W-1:0] STORE_LIMIT = 5'd24;
  localparam int PAYLOAD_W = 8 * STORE_DEPTH;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAD_PATTERN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAD_LENGTH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TAIL_PATTERN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TAIL_LENGTH = 3'd4;

  typedef struct packed {
    logic             frame_mode;
    logic [PAT_W-1:0] head_pattern;
    logic [LEN_W-1:0] head_length;
    logic [PAT_W-1:0] tail_pattern;
    logic [LEN_W-1:0] tail_length;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } qword_t;

  function automatic logic [EFF_W-1:0] eff_len(input logic [LEN_W-1:0] len);
    logic [EFF_W-1:0] ext;
    ext = {1'b0, len};
    if (ext == '0) begin
      return EFF_W'(1);
    end else if (ext > EFF_W'(MAX_PATTERN_BYTES)) begin
      return EFF_W'(MAX_PATTERN_BYTES);
    end
    return ext;
  endfunction

  function automatic logic [7:0] pattern_byte(input logic [PAT_W-1:0] pat,
                                              input logic [MCNT_W-1:0] k);
    logic [PAT_W-1:0] sh;
    sh = pat >> {k, 3'b000};
    if ({1'b0, k} >= EFF_W'(PAT_BYTES)) begin
      return 8'h00;
    end
    return sh[7:0];
  endfunction

endpackage

/* rtl/core/htdsc_front.sv */
module htdsc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  htdsc_pkg::cfg_t   cfg_i,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,   // [7:0] rx_byte
  input  logic              q_full_i,
  output htdsc_pkg::qword_t push_o
);
  import htdsc_pkg::*;

  logic              in_frame_q, in_frame_d;
  logic [MCNT_W-1:0] head_cnt_q, head_cnt_d;
  logic [MCNT_W-1:0] tail_cnt_q, tail_cnt_d;
  logic              accept;

  assign s_axis_tready = !q_full_i;
  assign accept = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_frame_d  = in_frame_q;
    head_cnt_d  = head_cnt_q;
    tail_cnt_d  = tail_cnt_q;
    push_o.valid = 1'b0;
    push_o.data  = s_axis_tdata;
    if (accept) begin
      if (!in_frame_q) begin
        if (s_axis_tdata == pattern_byte(cfg_i.head_pattern, head_cnt_q)) begin
          if (({1'b0, head_cnt_q} + EFF_W'(1)) >= eff_len(cfg_i.head_length)) begin
            head_cnt_d = '0;
            in_frame_d = 1'b1;
          end else begin
            head_cnt_d = head_cnt_q + MCNT_W'(1);
          end
        end
      end else if (s_axis_tdata == pattern_byte(cfg_i.tail_pattern, tail_cnt_q)) begin
        if (({1'b0, tail_cnt_q} + EFF_W'(1)) >= eff_len(cfg_i.tail_length)) begin
          tail_cnt_d = '0;
          in_frame_d = 1'b0;
        end else begin
          tail_cnt_d = tail_cnt_q + MCNT_W'(1);
        end
      end else begin
        push_o.valid = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      head_cnt_q <= '0;
      tail_cnt_q <= '0;
    end else begin
      in_frame_q <= in_frame_d;
      head_cnt_q <= head_cnt_d;
      tail_cnt_q <= tail_cnt_d;
    end
  end

endmodule

/* rtl/core/htdsc_queue.sv */
module htdsc_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  htdsc_pkg::qword_t push_i,
  output logic              full_o,
  input  logic              pop_i,
  output htdsc_pkg::qword_t head_o
);
  import htdsc_pkg::*;

  logic [7:0]        mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o      = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.data  = mem_q[rd_ptr_q];
  assign do_push = push_i.valid && !full_o;
  assign do_pop  = pop_i && head_o.valid;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.data;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count past depth");

  a_push_not_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.valid |-> !full_o)
    else $error("word pushed into full queue");

  a_count_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> cnt_q == $past(cnt_q) + QCNT_W'(1))
    else $error("queue count did not advance on push");

endmodule

/* rtl/core/htdsc_back.sv */
module htdsc_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           frame_mode_i,
  input  htdsc_pkg::qword_t              head_i,
  output logic                           pop_o,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [htdsc_pkg::PAYLOAD_W-1:0] m_axis_tdata,  // payload_word0, word1, word2
  output logic                           m_axis_tuser   // record_mode
);
  import htdsc_pkg::*;

  logic [7:0]           store_q [STORE_DEPTH];
  logic [RCNT_W-1:0]    cnt_q, cnt_d;
  logic [7:0]           sum_q, sum_d;
  logic                 out_valid_q, out_valid_d;
  logic [PAYLOAD_W-1:0] out_data_q;
  logic                 out_mode_q;
  logic [PAYLOAD_W-1:0] payload;
  logic [RCNT_W-1:0]    rec_last, pay_len;
  logic                 is_last, load;

  assign rec_last = frame_mode_i ? REC_LAST_M1 : REC_LAST_M0;
  assign pay_len  = frame_mode_i ? PAY_LEN_M1 : PAY_LEN_M0;
  assign is_last  = (cnt_q >= rec_last);
  assign pop_o    = head_i.valid && (!is_last || !out_valid_q || m_axis_tready);
  assign load     = pop_o && is_last && (head_i.data == sum_q);

  always_comb begin
    for (int i = 0; i < STORE_DEPTH; i++) begin
      payload[8*i +: 8] = (RCNT_W'(i) < pay_len) ? store_q[i] : 8'h00;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    sum_d = sum_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    if (pop_o) begin
      if (is_last) begin
        cnt_d = '0;
        sum_d = '0;
      end else begin
        cnt_d = cnt_q + RCNT_W'(1);
        sum_d = sum_q + head_i.data;
      end
    end
    if (load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && !is_last && (cnt_q < STORE_LIMIT)) begin
      store_q[cnt_q] <= head_i.data;
    end
    if (load) begin
      out_data_q <= payload;
      out_mode_q <= frame_mode_i;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_mode_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= REC_LAST_M0)
    else $error("record count past record length");

  a_check_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && is_last) |=> (cnt_q == '0) && (sum_q == '0))
    else $error("count or sum not cleared after check byte");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> (!out_valid_q || m_axis_tready))
    else $error("pending result overwritten");

endmodule

/* rtl/core/header_trailer_deframer_sum_check.sv */
// A record's check byte passes through the queue; when it matches the running sum, the
// result is registered and held on m_axis_tvalid until m_axis_tready takes it.
// Throughput: one byte per cycle while s_axis_tready is high; each payload byte needs one compare, an 8-bit add
// and one store write, and a 4-word queue decouples input from result stalls.
// s_axis_tready drops only while that queue is full.
// Reset (rst_ni low, asynchronous): outside frame, counts and sum cleared,
// queue and result register empty, registers at their reset values.
module header_trailer_deframer_sum_check (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [htdsc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [htdsc_pkg::PAT_W-1:0]       cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,  // [7:0] rx_byte
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [63:0] payload_word0, [127:64] payload_word1, [191:128] payload_word2
  output logic [htdsc_pkg::PAYLOAD_W-1:0]   m_axis_tdata,
  output logic                              m_axis_tuser   // [0] record_mode
);
  import htdsc_pkg::*;

  cfg_t   cfg_q;
  qword_t push, head;
  logic   q_full, pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_mode   <= 1'b0;
      cfg_q.head_pattern <= '0;
      cfg_q.head_length  <= LEN_W'(1);
      cfg_q.tail_pattern <= '0;
      cfg_q.tail_length  <= LEN_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_FRAME_MODE:   cfg_q.frame_mode   <= cfg_data_i[0];
        CFG_HEAD_PATTERN: cfg_q.head_pattern <= cfg_data_i;
        CFG_HEAD_LENGTH:  cfg_q.head_length  <= cfg_data_i[LEN_W-1:0];
        CFG_TAIL_PATTERN: cfg_q.tail_pattern <= cfg_data_i;
        CFG_TAIL_LENGTH:  cfg_q.tail_length  <= cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  htdsc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .q_full_i      (q_full),
    .push_o        (push)
  );

  htdsc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (q_full),
    .pop_i  (pop),
    .head_o (head)
  );

  htdsc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .frame_mode_i  (cfg_q.frame_mode),
    .head_i        (head),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule
